// ===== src/smpq_pkg.sv =====
// Shared types, codes and defaults for the stable min-first priority queue.
`timescale 1ns / 1ps

package smpq_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int PRIORITY_BITS_DEF = 8;
  localparam int VALUE_BITS        = 32;
  localparam int IN_PRIORITY_BITS  = 8;
  localparam int STATUS_BITS       = 2;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

  // operation broadcast to every cell in the row
  typedef struct packed {
    logic ins;  // insert that fits
    logic rem;  // removal from a non-empty queue
  } ctrl_t;

endpackage

// ===== src/stable_min_priority_queue.sv =====
// Top level of the stable min-first priority queue: command port, cell row, result register.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Beat
// command   in         start high, busy low      cmd, in_value, in_priority
// result    out        done high for one cycle   status, out_value
//
// A new command is taken in every cycle and busy
// never rises. The result beat appears on the cycle after the command beat.
// The row of DEPTH cells is kept sorted by priority, oldest first among
// equal priorities, so cell 0 always holds the entry to remove next.
// An insert shifts the tail down by one slot, a removal shifts all up by one.
// Reset clears the valid bits at once; no clearing pass is needed.
// The receiver cannot stall: each result is taken in the cycle it shows.

module stable_min_priority_queue #(
  parameter int DEPTH         = smpq_pkg::DEPTH_DEF,
  parameter int PRIORITY_BITS = smpq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  cmd,
  input  logic signed [smpq_pkg::VALUE_BITS-1:0] in_value,
  input  logic [smpq_pkg::IN_PRIORITY_BITS-1:0] in_priority,
  output logic                                  done,
  output logic [smpq_pkg::STATUS_BITS-1:0]      status,
  output logic signed [smpq_pkg::VALUE_BITS-1:0] out_value
);

  // Neighbor links; slot j+1 is cell j, slots 0 and DEPTH+1 are empty ends.
  logic                            link_valid [0:DEPTH+1];
  logic [PRIORITY_BITS-1:0]        link_pri   [0:DEPTH+1];
  logic [smpq_pkg::VALUE_BITS-1:0] link_value [0:DEPTH+1];
  logic                            link_place [0:DEPTH];

  logic [31:0]                     pri_ext;
  logic [PRIORITY_BITS-1:0]        new_pri;
  logic                            accept;
  logic                            full;
  logic                            empty;
  smpq_pkg::ctrl_t                 ctrl;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // keep only the low PRIORITY_BITS bits of the incoming priority
  assign pri_ext = 32'(in_priority);
  assign new_pri = pri_ext[PRIORITY_BITS-1:0];

  assign full  = link_valid[DEPTH];
  assign empty = !link_valid[1];

  assign ctrl.ins = accept && (cmd == smpq_pkg::CMD_INSERT) && !full;
  assign ctrl.rem = accept && (cmd == smpq_pkg::CMD_REMOVE) && !empty;

  // ends of the row
  assign link_valid[0]       = 1'b0;
  assign link_pri[0]         = '0;
  assign link_value[0]       = '0;
  assign link_place[0]       = 1'b0;
  assign link_valid[DEPTH+1] = 1'b0;
  assign link_pri[DEPTH+1]   = '0;
  assign link_value[DEPTH+1] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    smpq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_pri   (new_pri),
      .new_value (in_value),
      .prev_place(link_place[i]),
      .prev_valid(link_valid[i]),
      .prev_pri  (link_pri[i]),
      .prev_value(link_value[i]),
      .next_valid(link_valid[i+2]),
      .next_pri  (link_pri[i+2]),
      .next_value(link_value[i+2]),
      .place     (link_place[i+1]),
      .valid     (link_valid[i+1]),
      .pri       (link_pri[i+1]),
      .value     (link_value[i+1])
    );
  end

  // result register: one beat per accepted command
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (cmd == smpq_pkg::CMD_INSERT) begin
        status    <= full ? smpq_pkg::STATUS_FULL : smpq_pkg::STATUS_DONE;
        out_value <= '0;
      end else if (empty) begin
        status    <= smpq_pkg::STATUS_EMPTY;
        out_value <= '0;
      end else begin
        status    <= smpq_pkg::STATUS_DONE;
        out_value <= link_value[1];
      end
    end
  end

endmodule

// ===== src/smpq_cell.sv =====
// One slot of the sorted shift row: holds an entry, takes from a neighbor or the new item.
`timescale 1ns / 1ps

module smpq_cell #(
  parameter int PRIORITY_BITS = smpq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  smpq_pkg::ctrl_t                 ctrl,
  input  logic [PRIORITY_BITS-1:0]        new_pri,
  input  logic [smpq_pkg::VALUE_BITS-1:0] new_value,
  input  logic                            prev_place,
  input  logic                            prev_valid,
  input  logic [PRIORITY_BITS-1:0]        prev_pri,
  input  logic [smpq_pkg::VALUE_BITS-1:0] prev_value,
  input  logic                            next_valid,
  input  logic [PRIORITY_BITS-1:0]        next_pri,
  input  logic [smpq_pkg::VALUE_BITS-1:0] next_value,
  output logic                            place,
  output logic                            valid,
  output logic [PRIORITY_BITS-1:0]        pri,
  output logic [smpq_pkg::VALUE_BITS-1:0] value
);

  // new item belongs at or before this slot (strictly smaller keeps ties stable)
  assign place = !valid || (new_pri < pri);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.rem) begin
      valid <= next_valid;
    end else if (ctrl.ins && place) begin
      valid <= prev_place ? prev_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rem) begin
      pri   <= next_pri;
      value <= next_value;
    end else if (ctrl.ins && place) begin
      if (prev_place) begin
        pri   <= prev_pri;
        value <= prev_value;
      end else begin
        pri   <= new_pri;
        value <= new_value;
      end
    end
  end

endmodule
